// File: hdl/paced_priority_queue_scheduler_core_defines.svh
// assertion macros for the paced priority queue scheduler
// used by paced_priority_queue_scheduler_core, expects clk and rst_n in scope
`ifndef PACED_PRIORITY_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define PACED_PRIORITY_QUEUE_SCHEDULER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PPQS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ppqs check failed");
`define PPQS_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("ppqs check failed");
`else
`define PPQS_ASSERT_ALWAYS(lbl, expr)
`define PPQS_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

// File: hdl/ppqs_pkg.sv
// types and fixed constants of the paced priority queue scheduler
// no dependencies
package ppqs_pkg;

  localparam int TAG_W        = 16;
  localparam int PAUSE_W      = 16;
  localparam int CLASS_W      = 8;
  localparam int SEND_CLASS_W = 7;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;

  localparam logic [TAG_W-1:0]   TAG_CLASS_MASK = 16'hFFF0;
  localparam logic [CLASS_W-1:0] GROUP_B_START  = 8'd32;
  localparam logic [CLASS_W-1:0] GROUP_C_START  = 8'd64;
  localparam logic [CLASS_W-1:0] GROUP_END      = 8'd96;

  localparam logic [PAUSE_W-1:0] PAUSE_A_RST = 16'd12;
  localparam logic [PAUSE_W-1:0] PAUSE_B_RST = 16'd6;
  localparam logic [PAUSE_W-1:0] PAUSE_C_RST = 16'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ    = 2'd0,
    MODE_TXDONE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAUSE_A = 2'd0,
    CFG_PAUSE_B = 2'd1,
    CFG_PAUSE_C = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

// File: hdl/paced_priority_queue_scheduler_core.sv
// paced strict priority scheduler: per-class packet counts and pause timers
// in one memory, swept entry by entry through a shared update unit
// depends on ppqs_pkg and paced_priority_queue_scheduler_core_defines.svh
// one word at a time: a new input word is taken only in idle, after the last word's
// sweep over the queue memory (one entry read and written back per cycle) and
// the loading of its result word into the output register
// reset: synchronous active low, clears control, timers and counts at once
// through per-entry valid bits, no clearing pass
`include "paced_priority_queue_scheduler_core_defines.svh"

module paced_priority_queue_scheduler_core
  import ppqs_pkg::*;
#(
  parameter int QUEUE_COUNT = 128,
  parameter int QUEUE_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // priority_tag[15:0]
  input  logic [1:0]           in_tuser,   // mode[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // send_class[6:0], dropped[7]
  output logic [0:0]           out_tuser,  // send_valid[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int IW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = CW + PAUSE_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_COUNT - 1);
  localparam logic [CW-1:0] DEPTH_MAX = CW'(QUEUE_DEPTH);

  state_t state_r, state_nxt;

  logic [PAUSE_W-1:0] pause_a_r, pause_b_r, pause_c_r;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               rd_more_r, rd_more_nxt;
  logic               pend_r, pend_nxt;
  logic [IW-1:0]      pend_idx_r, pend_idx_nxt;
  mode_t              mode_r, mode_nxt;
  logic [CLASS_W-1:0] cls_r, cls_nxt;
  logic               busy_r, busy_nxt;
  logic               served_r, served_nxt;
  logic [SEND_CLASS_W-1:0] srv_class_r, srv_class_nxt;
  logic               drop_r, drop_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  logic [EW-1:0]          mem [QUEUE_COUNT];
  logic [QUEUE_COUNT-1:0] valid_r;
  logic [EW-1:0]          rdata_r;
  logic                   rvld_r;

  logic               wr_en;
  logic [EW-1:0]      wr_data;
  logic [CW-1:0]      cnt, cnt_n;
  logic [PAUSE_W-1:0] pause, pause_n, group_pause;
  logic [CLASS_W-1:0] idx8, in_cls;
  logic               in_acc;

  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign in_cls     = CLASS_W'((in_tdata & TAG_CLASS_MASK) >> 8);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_a_r <= PAUSE_A_RST;
      pause_b_r <= PAUSE_B_RST;
      pause_c_r <= PAUSE_C_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PAUSE_A: pause_a_r <= cfg_data;
        CFG_PAUSE_B: pause_b_r <= cfg_data;
        CFG_PAUSE_C: pause_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // queue memory: counts in low bits, pause timer above
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_idx_r];
    if (wr_en) begin
      mem[pend_idx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      rvld_r <= valid_r[rd_idx_r];
      if (wr_en) begin
        valid_r[pend_idx_r] <= 1'b1;
      end
    end
  end

  // shared entry update unit
  always_comb begin
    idx8 = CLASS_W'(pend_idx_r);
    cnt   = rvld_r ? rdata_r[CW-1:0] : '0;
    pause = rvld_r ? rdata_r[EW-1:CW] : '0;
    if (idx8 < GROUP_B_START) begin
      group_pause = pause_a_r;
    end else if (idx8 < GROUP_C_START) begin
      group_pause = pause_b_r;
    end else if (idx8 < GROUP_END) begin
      group_pause = pause_c_r;
    end else begin
      group_pause = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_idx_r     <= '0;
      rd_more_r    <= 1'b0;
      pend_r       <= 1'b0;
      busy_r       <= 1'b0;
      served_r     <= 1'b0;
      drop_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_more_r    <= rd_more_nxt;
      pend_r       <= pend_nxt;
      busy_r       <= busy_nxt;
      served_r     <= served_nxt;
      drop_r       <= drop_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    mode_r      <= mode_nxt;
    cls_r       <= cls_nxt;
    srv_class_r <= srv_class_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    rd_more_nxt    = rd_more_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    mode_nxt       = mode_r;
    cls_nxt        = cls_r;
    busy_nxt       = busy_r;
    served_nxt     = served_r;
    srv_class_nxt  = srv_class_r;
    drop_nxt       = drop_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    wr_en          = 1'b0;
    cnt_n          = cnt;
    pause_n        = pause;
    wr_data        = {pause_n, cnt_n};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt     = ST_SWEEP;
          rd_idx_nxt    = '0;
          rd_more_nxt   = 1'b1;
          mode_nxt      = mode_t'(in_tuser);
          cls_nxt       = in_cls;
          served_nxt    = 1'b0;
          srv_class_nxt = '0;
          drop_nxt      = (mode_t'(in_tuser) == MODE_ENQ) &&
                          ({1'b0, in_cls} >= 9'(QUEUE_COUNT));
          if (mode_t'(in_tuser) == MODE_TXDONE) begin
            busy_nxt = 1'b0;
          end
        end
      end
      ST_SWEEP: begin
        if (rd_more_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (pend_r) begin
          wr_en = 1'b1;
          if (mode_r == MODE_TICK && pause != '0) begin
            pause_n = pause - 1'b1;
          end
          if (mode_r == MODE_ENQ && cls_r == idx8) begin
            if (cnt >= DEPTH_MAX) begin
              drop_nxt = 1'b1;
            end else begin
              cnt_n = cnt + 1'b1;
            end
          end
          if (mode_r != MODE_NONE && !busy_r && !served_r &&
              cnt_n != '0 && pause_n == '0) begin
            cnt_n         = cnt_n - 1'b1;
            pause_n       = group_pause;
            busy_nxt      = 1'b1;
            served_nxt    = 1'b1;
            srv_class_nxt = idx8[SEND_CLASS_W-1:0];
          end
          wr_data = {pause_n, cnt_n};
          if (pend_idx_r == LAST_IDX) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {drop_r, srv_class_r};
          out_user_nxt   = served_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `PPQS_ASSERT_ALWAYS(a_no_work_when_ready, !(in_tready && pend_r))
  `PPQS_ASSERT_ALWAYS(a_served_means_busy, !served_r || busy_r)
  `PPQS_ASSERT_NEXT(a_accept_starts_sweep, in_tvalid && in_tready, state_r == ST_SWEEP)
  `PPQS_ASSERT_ALWAYS(a_idle_class_zero, !out_tvalid || out_tuser[0] || out_tdata[6:0] == 7'd0)

endmodule
